[hw/rtl/fvnh_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the fractal value-noise height unit.
// Style table with precomputed cell-division reciprocals; no dependencies.
package fvnh_pkg;

  typedef struct packed {
    logic [18:0] c;
    logic [17:0] d;
    logic [39:0] m;
  } div_coef_t;

  typedef struct packed {
    logic [11:0] hero_amp;
    logic [11:0] mac_amp;
    logic [11:0] mid_amp;
    logic [11:0] fine_amp;
    logic [15:0] ridge;
    logic        ridge_en;
  } mix_cfg_t;

  typedef struct packed {
    div_coef_t hero_u;
    div_coef_t hero_v;
    div_coef_t mac;
    div_coef_t mid;
    div_coef_t fine;
    mix_cfg_t  mix;
    logic      aniso;
  } style_row_t;

  localparam int unsigned NumStyles = 3;
  localparam int unsigned TableRows = 3;
  localparam logic [1:0]  MaxRow    = 2'(((NumStyles < TableRows) ? NumStyles : TableRows) - 1);

  localparam logic CfgIdxSeed  = 1'b0;
  localparam logic CfgIdxStyle = 1'b1;

  localparam logic [31:0] HashMulX = 32'h9E37_79B9;
  localparam logic [31:0] HashMulZ = 32'h85EB_CA77;
  localparam logic [31:0] HashMix1 = 32'h7FEB_352D;
  localparam logic [31:0] HashMix2 = 32'h846C_A68B;

  localparam logic [31:0] SeedSalt [4] = '{32'h0, 32'h1111, 32'h2222, 32'h3333};

  localparam logic [15:0]        Gain06 = 16'd39322;
  localparam logic signed [35:0] Base   = 36'sd33554432;

  localparam style_row_t StyleTab [TableRows] = '{
    '{hero_u: '{c: 19'd46341,  d: 18'd11776,  m: 40'((64'd46341 << 32) / 64'd11776)},
      hero_v: '{c: 19'd463410, d: 18'd259072, m: 40'((64'd463410 << 32) / 64'd259072)},
      mac:    '{c: 19'd256,    d: 18'd21,     m: 40'((64'd256 << 32) / 64'd21)},
      mid:    '{c: 19'd256,    d: 18'd10,     m: 40'((64'd256 << 32) / 64'd10)},
      fine:   '{c: 19'd256,    d: 18'd5,      m: 40'((64'd256 << 32) / 64'd5)},
      mix:    '{hero_amp: 12'd3584, mac_amp: 12'd1280, mid_amp: 12'd256, fine_amp: 12'd61,
                ridge: 16'd32768, ridge_en: 1'b1},
      aniso:  1'b1},
    '{hero_u: '{c: 19'd256,    d: 18'd52,     m: 40'((64'd256 << 32) / 64'd52)},
      hero_v: '{c: 19'd256,    d: 18'd52,     m: 40'((64'd256 << 32) / 64'd52)},
      mac:    '{c: 19'd256,    d: 18'd23,     m: 40'((64'd256 << 32) / 64'd23)},
      mid:    '{c: 19'd256,    d: 18'd11,     m: 40'((64'd256 << 32) / 64'd11)},
      fine:   '{c: 19'd256,    d: 18'd6,      m: 40'((64'd256 << 32) / 64'd6)},
      mix:    '{hero_amp: 12'd2816, mac_amp: 12'd1024, mid_amp: 12'd205, fine_amp: 12'd46,
                ridge: 16'd0, ridge_en: 1'b0},
      aniso:  1'b0},
    '{hero_u: '{c: 19'd46341,  d: 18'd11264,  m: 40'((64'd46341 << 32) / 64'd11264)},
      hero_v: '{c: 19'd463410, d: 18'd168960, m: 40'((64'd463410 << 32) / 64'd168960)},
      mac:    '{c: 19'd256,    d: 18'd19,     m: 40'((64'd256 << 32) / 64'd19)},
      mid:    '{c: 19'd256,    d: 18'd10,     m: 40'((64'd256 << 32) / 64'd10)},
      fine:   '{c: 19'd256,    d: 18'd5,      m: 40'((64'd256 << 32) / 64'd5)},
      mix:    '{hero_amp: 12'd3328, mac_amp: 12'd1152, mid_amp: 12'd230, fine_amp: 12'd56,
                ridge: 16'd19661, ridge_en: 1'b1},
      aniso:  1'b1}
  };

endpackage

[hw/rtl/fvnh_cell_div.sv]
`timescale 1ns / 1ps
// Four-stage floor(w*c/d) by reciprocal multiply with one-step correction.
// Gives lattice cell index and Q0.16 fraction. Uses fvnh_pkg.
module fvnh_cell_div #(
  parameter int unsigned W = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [W-1:0] w_i,
  input  fvnh_pkg::div_coef_t coef_i,
  output logic                valid_o,
  output logic [31:0]         cell_o,
  output logic [15:0]         frac_o
);
  import fvnh_pkg::*;

  localparam int unsigned QW = W + 7;
  localparam int unsigned PW = W + 21;
  localparam int unsigned SW = W + 41;
  localparam int unsigned EW = (W > 24) ? W : 24;
  localparam int unsigned CW = QW - 16;

  logic [3:0] vld_q;

  logic signed [PW-1:0] plo_d, phi_d, plo_q, phi_q;
  logic signed [W-1:0]  w1_q, w2_q;
  logic signed [SW-1:0] sum;
  logic signed [QW-1:0] qest_d, qest_q, qest3_q, q_d, q_q;
  logic signed [EW-1:0] wext;
  logic [23:0]          rc_d, qd_d, rc_q, qd_q;
  logic signed [23:0]   r;
  logic signed [24:0]   r_w, d_w;

  always_comb begin
    plo_d  = w_i * $signed({1'b0, coef_i.m[19:0]});
    phi_d  = w_i * $signed({1'b0, coef_i.m[39:20]});
    sum    = (SW'(phi_q) <<< 20) + SW'(plo_q);
    qest_d = QW'(sum >>> 32);
    wext   = EW'(w2_q);
    rc_d   = wext[23:0] * 24'(coef_i.c);
    qd_d   = qest_q[23:0] * 24'(coef_i.d);
    r      = $signed(rc_q - qd_q);
    r_w    = 25'(r);
    d_w    = $signed({7'b0, coef_i.d});
    if (r[23]) begin
      q_d = qest3_q - QW'(1);
    end else if (r_w >= d_w) begin
      q_d = qest3_q + QW'(1);
    end else begin
      q_d = qest3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    plo_q   <= plo_d;
    phi_q   <= phi_d;
    w1_q    <= w_i;
    qest_q  <= qest_d;
    w2_q    <= w1_q;
    rc_q    <= rc_d;
    qd_q    <= qd_d;
    qest3_q <= qest_q;
    q_q     <= q_d;
  end

  assign valid_o = vld_q[3];
  assign cell_o  = {{(32 - CW){q_q[QW-1]}}, q_q[QW-1:16]};
  assign frac_o  = q_q[15:0];

  // estimate is off by at most one cell step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> ((r_w >= -d_w) && (r_w < (d_w <<< 1))))
    else $error("cell divide estimate out of correction range");

endmodule

[hw/rtl/fvnh_octave.sv]
`timescale 1ns / 1ps
// One octave of value noise: corner hashes, smoothstep, bilinear blend.
// Six register stages. Uses fvnh_pkg.
module fvnh_octave (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [31:0]        cell_x_i,
  input  logic [31:0]        cell_z_i,
  input  logic [15:0]        frac_x_i,
  input  logic [15:0]        frac_z_i,
  input  logic [31:0]        seed_i,
  output logic               valid_o,
  output logic signed [15:0] noise_o
);
  import fvnh_pkg::*;

  logic [5:0] vld_q;

  // stage 1
  logic [31:0] kx_d, kz_d, kx_q, kz_q, sqx, sqz;
  logic [15:0] t2x_q, t2z_q, fx1_q, fz1_q;
  // stage 2
  logic [31:0] h0 [4];
  logic [31:0] h1 [4];
  logic [31:0] m1_d [4];
  logic [31:0] m1_q [4];
  logic [17:0] cx, cz;
  logic [33:0] spx, spz;
  logic [16:0] sx2_q, sz2_q;
  // stage 3
  logic [31:0] m2_d [4];
  logic [31:0] m2_q [4];
  logic [16:0] sx3_q, sz3_q;
  // stage 4
  logic signed [15:0] l [4];
  logic signed [34:0] pa_d, pb_d, pa_q, pb_q;
  logic signed [15:0] l0_q, l2_q;
  logic [16:0]        sz4_q;
  // stage 5
  logic signed [15:0] a, b, a5_q;
  logic signed [34:0] pc_d, pc_q;
  // stage 6
  logic signed [15:0] noise_d, noise_q;

  always_comb begin
    kx_d = cell_x_i * HashMulX;
    kz_d = cell_z_i * HashMulZ;
    sqx  = 32'(frac_x_i) * 32'(frac_x_i);
    sqz  = 32'(frac_z_i) * 32'(frac_z_i);
    for (int c = 0; c < 4; c++) begin
      h0[c]   = (kx_q + ((c % 2 == 1) ? HashMulX : 32'h0))
              ^ (kz_q + ((c / 2 == 1) ? HashMulZ : 32'h0)) ^ seed_i;
      h1[c]   = h0[c] ^ (h0[c] >> 16);
      m1_d[c] = h1[c] * HashMix1;
      m2_d[c] = (m1_q[c] ^ (m1_q[c] >> 15)) * HashMix2;
      l[c]    = $signed(m2_q[c][31:16]);
    end
    cx      = 18'd196608 - {1'b0, fx1_q, 1'b0};
    cz      = 18'd196608 - {1'b0, fz1_q, 1'b0};
    spx     = 34'(t2x_q) * 34'(cx);
    spz     = 34'(t2z_q) * 34'(cz);
    pa_d    = ($signed({l[1][15], l[1]}) - $signed({l[0][15], l[0]}))
            * $signed({1'b0, sx3_q});
    pb_d    = ($signed({l[3][15], l[3]}) - $signed({l[2][15], l[2]}))
            * $signed({1'b0, sx3_q});
    a       = l0_q + 16'(pa_q >>> 16);
    b       = l2_q + 16'(pb_q >>> 16);
    pc_d    = ($signed({b[15], b}) - $signed({a[15], a})) * $signed({1'b0, sz4_q});
    noise_d = a5_q + 16'(pc_q >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    kx_q    <= kx_d;
    kz_q    <= kz_d;
    t2x_q   <= sqx[31:16];
    t2z_q   <= sqz[31:16];
    fx1_q   <= frac_x_i;
    fz1_q   <= frac_z_i;
    m1_q    <= m1_d;
    sx2_q   <= spx[32:16];
    sz2_q   <= spz[32:16];
    m2_q    <= m2_d;
    sx3_q   <= sx2_q;
    sz3_q   <= sz2_q;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    l0_q    <= l[0];
    l2_q    <= l[2];
    sz4_q   <= sz3_q;
    a5_q    <= a;
    pc_q    <= pc_d;
    noise_q <= noise_d;
  end

  assign valid_o = vld_q[5];
  assign noise_o = noise_q;

  // smoothstep weight never reaches one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> ((sx2_q <= 17'd65535) && (sz2_q <= 17'd65535)))
    else $error("smoothstep weight overflow");

endmodule

[hw/rtl/fvnh_mix.sv]
`timescale 1ns / 1ps
// Ridge fold, octave gains, sums and Q8.8 round and saturate.
// Five register stages. Uses fvnh_pkg.
module fvnh_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  fvnh_pkg::mix_cfg_t cfg_i,
  input  logic signed [15:0] hero_i,
  input  logic signed [15:0] mac_i,
  input  logic signed [15:0] mid_i,
  input  logic signed [15:0] fine_i,
  output logic               valid_o,
  output logic signed [15:0] full_o,
  output logic signed [15:0] contour_o
);
  import fvnh_pkg::*;

  function automatic logic signed [15:0] sat_q88(input logic signed [35:0] acc);
    logic signed [35:0] v;
    v = (acc + 36'sd16384) >>> 15;
    if (v > 36'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -36'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  logic [4:0] vld_q;

  logic [16:0]        inv_r, mag_c;
  logic [15:0]        abs_h;
  logic signed [33:0] ph_d, pr_d, ph_q, pr_q;
  logic signed [15:0] mac1_q, mid1_q, fine1_q, hero1_q;
  logic signed [34:0] rsum;
  logic signed [17:0] hero2_d, hero2_q;
  logic signed [28:0] pm2_d, pd2_d, pf2_d, pm2_q, pd2_q, pf2_q;
  logic signed [30:0] phh3_d, phh3_q, sum3_d, sum3_q;
  logic signed [45:0] pg3_d, pg3_q;
  logic signed [35:0] full4_d, cont4_d, full4_q, cont4_q;
  logic signed [15:0] full_q, cont_q;

  always_comb begin
    abs_h   = hero_i[15] ? 16'(-hero_i) : 16'(hero_i);
    inv_r   = 17'h10000 - {1'b0, cfg_i.ridge};
    mag_c   = 17'h08000 - {1'b0, abs_h};
    ph_d    = hero_i * $signed({1'b0, inv_r});
    pr_d    = $signed({1'b0, mag_c}) * $signed({1'b0, cfg_i.ridge});
    rsum    = 35'(ph_q) + 35'(pr_q);
    hero2_d = cfg_i.ridge_en ? 18'(rsum >>> 16) : 18'(hero1_q);
    pm2_d   = mac1_q * $signed({1'b0, cfg_i.mac_amp});
    pd2_d   = mid1_q * $signed({1'b0, cfg_i.mid_amp});
    pf2_d   = fine1_q * $signed({1'b0, cfg_i.fine_amp});
    phh3_d  = hero2_q * $signed({1'b0, cfg_i.hero_amp});
    pg3_d   = pm2_q * $signed({1'b0, Gain06});
    sum3_d  = 31'(pm2_q) + 31'(pd2_q) + 31'(pf2_q);
    full4_d = Base + 36'(phh3_q) + 36'(sum3_q);
    cont4_d = Base + 36'(phh3_q) + 36'(pg3_q >>> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q    <= ph_d;
    pr_q    <= pr_d;
    hero1_q <= hero_i;
    mac1_q  <= mac_i;
    mid1_q  <= mid_i;
    fine1_q <= fine_i;
    hero2_q <= hero2_d;
    pm2_q   <= pm2_d;
    pd2_q   <= pd2_d;
    pf2_q   <= pf2_d;
    phh3_q  <= phh3_d;
    pg3_q   <= pg3_d;
    sum3_q  <= sum3_d;
    full4_q <= full4_d;
    cont4_q <= cont4_d;
    full_q  <= sat_q88(full4_q);
    cont_q  <= sat_q88(cont4_q);
  end

  assign valid_o   = vld_q[4];
  assign full_o    = full_q;
  assign contour_o = cont_q;

endmodule

[hw/rtl/fractal_value_noise_height_unit.sv]
`timescale 1ns / 1ps
// Top level of the fractal value-noise height unit.
// Uses fvnh_pkg, fvnh_cell_div, fvnh_octave and fvnh_mix.
//
// Takes one coordinate beat per clock (busy stays low) and returns both
// heights for each beat taken, marked by done_o for one cycle;
// the output cannot be held off, so the caller must take it then. Throughput
// is one item per cycle; latency is set by the 4-stage cell divider, the
// 6-stage hash and blend pipeline and the 5-stage gain and saturation
// pipeline, plus the input register. Seed and style must only be written
// while no item is in flight.
module fractal_value_noise_height_unit #(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] x_pos_i,
  input  logic signed [COORD_WIDTH-1:0] z_pos_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i,
  output logic                          done_o,
  output logic signed [15:0]            full_height_o,
  output logic signed [15:0]            contour_height_o
);
  import fvnh_pkg::*;

  localparam int unsigned W       = COORD_WIDTH + 1;
  localparam int unsigned Latency = 16;

  logic [31:0] seed_q;
  logic [1:0]  style_q;
  logic [1:0]  row_idx;
  style_row_t  row;

  logic                accept;
  logic                vin_q;
  logic signed [W-1:0] wx, wz;
  logic signed [W-1:0] whu_d, whv_d, whu_q, whv_q, wx_q, wz_q;

  logic signed [W-1:0] w_x [4];
  logic signed [W-1:0] w_z [4];
  div_coef_t           coef_x [4];
  div_coef_t           coef_z [4];
  logic [3:0]          dv_x, dv_z, ov;
  logic [31:0]         cell_x [4];
  logic [31:0]         cell_z [4];
  logic [15:0]         frac_x [4];
  logic [15:0]         frac_z [4];
  logic signed [15:0]  noise [4];

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign row_idx = (style_q > MaxRow) ? MaxRow : style_q;
  assign row     = StyleTab[row_idx];

  always_comb begin
    wx    = W'(x_pos_i);
    wz    = W'(z_pos_i);
    whu_d = row.aniso ? (wx + wz) : wx;
    whv_d = row.aniso ? (wz - wx) : wz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      style_q <= '0;
      vin_q   <= 1'b0;
    end else begin
      vin_q <= accept;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgIdxSeed:  seed_q  <= cfg_wdata_i;
          CfgIdxStyle: style_q <= cfg_wdata_i[1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    whu_q <= whu_d;
    whv_q <= whv_d;
    wx_q  <= wx;
    wz_q  <= wz;
  end

  always_comb begin
    w_x[0]    = whu_q;
    w_z[0]    = whv_q;
    coef_x[0] = row.hero_u;
    coef_z[0] = row.hero_v;
    w_x[1]    = wx_q;
    w_z[1]    = wz_q;
    coef_x[1] = row.mac;
    coef_z[1] = row.mac;
    w_x[2]    = wx_q;
    w_z[2]    = wz_q;
    coef_x[2] = row.mid;
    coef_z[2] = row.mid;
    w_x[3]    = wx_q;
    w_z[3]    = wz_q;
    coef_x[3] = row.fine;
    coef_z[3] = row.fine;
  end

  for (genvar i = 0; i < 4; i++) begin : g_oct
    fvnh_cell_div #(.W(W)) u_div_x (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vin_q),
      .w_i     (w_x[i]),
      .coef_i  (coef_x[i]),
      .valid_o (dv_x[i]),
      .cell_o  (cell_x[i]),
      .frac_o  (frac_x[i])
    );

    fvnh_cell_div #(.W(W)) u_div_z (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vin_q),
      .w_i     (w_z[i]),
      .coef_i  (coef_z[i]),
      .valid_o (dv_z[i]),
      .cell_o  (cell_z[i]),
      .frac_o  (frac_z[i])
    );

    fvnh_octave u_octave (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (dv_x[i] && dv_z[i]),
      .cell_x_i (cell_x[i]),
      .cell_z_i (cell_z[i]),
      .frac_x_i (frac_x[i]),
      .frac_z_i (frac_z[i]),
      .seed_i   (seed_q ^ SeedSalt[i]),
      .valid_o  (ov[i]),
      .noise_o  (noise[i])
    );
  end

  fvnh_mix u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (&ov),
    .cfg_i     (row.mix),
    .hero_i    (noise[0]),
    .mac_i     (noise[1]),
    .mid_i     (noise[2]),
    .fine_i    (noise[3]),
    .valid_o   (done_o),
    .full_o    (full_height_o),
    .contour_o (contour_height_o)
  );

  // every result beat traces back to an accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result beat without matching input beat");

endmodule
